### rtl/core/abis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abis_pkg: shared types, codes and helpers for the ARGB surface blender
// Word formats, destination format codes, register indexes and the
// divide-by-255 and mask normalization helpers.
// ----------------------------------------------------------------------------
package abis_pkg;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int MASK_W      = 16;
   localparam int SHIFT_W     = 4;
   localparam int NUM_W       = 24;   // widest dividend into div255
   localparam int QUO_W       = 17;   // widest quotient out of div255

   localparam logic [MASK_W-1:0] DEFAULT_RED_MASK   = 16'h7c00;
   localparam logic [MASK_W-1:0] DEFAULT_GREEN_MASK = 16'h03e0;
   localparam logic [MASK_W-1:0] DEFAULT_BLUE_MASK  = 16'h001f;

   typedef enum logic [1:0] {
      FMT_16BPP = 2'd0,
      FMT_24BPP = 2'd1,
      FMT_32BPP = 2'd2
   } dest_format_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEST_FORMAT = 2'd0,
      CSR_RED_MASK    = 2'd1,
      CSR_GREEN_MASK  = 2'd2,
      CSR_BLUE_MASK   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [31:0] src_pixel;
      logic [31:0] dst_pixel;
   } req_word_type;

   typedef struct packed {
      logic [31:0] new_pixel;
      logic        write_enable;
   } rsp_word_type;

   // Mask with trailing zeros stripped, plus the stripped count.
   typedef struct packed {
      logic [MASK_W-1:0]  norm;
      logic [SHIFT_W-1:0] shift;
   } mask_field_type;

   // Strip trailing zeros; a zero mask takes the given default.
   function automatic mask_field_type norm_mask(input logic [MASK_W-1:0] raw,
                                                input logic [MASK_W-1:0] dflt);
      logic [MASK_W-1:0]  m;
      logic [SHIFT_W-1:0] tz;
      mask_field_type     res;
      m  = (raw == '0) ? dflt : raw;
      tz = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            tz = SHIFT_W'(i);
         end
      end
      res.norm  = m >> tz;
      res.shift = tz;
      return res;
   endfunction

   // Exact x/255 for 24-bit x: series estimate (low by at most one),
   // then one remainder compare.
   function automatic logic [QUO_W-1:0] div255(input logic [NUM_W-1:0] x);
      logic [NUM_W:0]   t;
      logic [QUO_W-1:0] q_est;
      logic [NUM_W:0]   q_x255;
      logic [NUM_W:0]   rem;
      t      = {1'b0, x} + {9'd0, x[NUM_W-1:8]} + {17'd0, x[NUM_W-1:16]};
      q_est  = t[NUM_W:8];
      q_x255 = {q_est, 8'd0} - {8'd0, q_est};
      rem    = {1'b0, x} - q_x255;
      if (rem >= 25'd255) begin
         return q_est + 17'd1;
      end
      return q_est;
   endfunction

endpackage

### rtl/core/argb_blend_into_surface.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_blend_into_surface: source-over ARGB8888 compositor, one pixel a cycle
// Blends a source pixel into the stored destination pixel at 24 or 32 bpp,
// or packs it through bitfield masks at 16 bpp.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_word (source and destination pixel) and pulse start.
//   A word is taken on every edge with start high; busy is always low, so a
//   new pixel may follow every cycle.
//   Response: rsp_valid strobes for one cycle with rsp_word. The receiver
//   cannot stall; every word must be taken when shown.
//   Path: a word passes the input register, the numerator register and the
//   result register, which drives rsp_valid and rsp_word.
//   Throughput: one pixel per clock, fully pipelined.
//   write_enable is low (and new_pixel zero) for a zero source alpha or an
//   unused format code.
//   CSR: csr_we/csr_index/csr_wdata write dest_format and the three 16 bpp
//   masks; write only while no pixel is in flight. Masks are normalized
//   (trailing zeros stripped) as they are written.
//   Reset (synchronous): flushes the pipe, format back to 32 bpp, masks to
//   the 5-5-5 defaults.
// ----------------------------------------------------------------------------
module argb_blend_into_surface (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  abis_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   output abis_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_we,
   input  logic [abis_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [abis_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import abis_pkg::*;

   // ---- configuration -------------------------------------------------
   // Channel slots: 0 blue, 1 green, 2 red (matches byte order).
   dest_format_type    fmt_cfg_ff;
   logic [MASK_W-1:0]  mask_norm_ff  [3];
   logic [SHIFT_W-1:0] mask_shift_ff [3];
   mask_field_type     wr_field;

   always_comb begin
      case (csr_index)
         CSR_RED_MASK:   wr_field = norm_mask(csr_wdata, DEFAULT_RED_MASK);
         CSR_GREEN_MASK: wr_field = norm_mask(csr_wdata, DEFAULT_GREEN_MASK);
         default:        wr_field = norm_mask(csr_wdata, DEFAULT_BLUE_MASK);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_cfg_ff       <= FMT_32BPP;
         mask_norm_ff[0]  <= 16'h001f;
         mask_shift_ff[0] <= 4'd0;
         mask_norm_ff[1]  <= 16'h001f;
         mask_shift_ff[1] <= 4'd5;
         mask_norm_ff[2]  <= 16'h001f;
         mask_shift_ff[2] <= 4'd10;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEST_FORMAT: fmt_cfg_ff <= dest_format_type'(csr_wdata[1:0]);
            CSR_RED_MASK: begin
               mask_norm_ff[2]  <= wr_field.norm;
               mask_shift_ff[2] <= wr_field.shift;
            end
            CSR_GREEN_MASK: begin
               mask_norm_ff[1]  <= wr_field.norm;
               mask_shift_ff[1] <= wr_field.shift;
            end
            default: begin
               mask_norm_ff[0]  <= wr_field.norm;
               mask_shift_ff[0] <= wr_field.shift;
            end
         endcase
      end
   end

   // Fully pipelined; never holds off a request.
   assign busy = 1'b0;

   // ---- stage 1: input register --------------------------------------
   logic         s1_valid_ff;
   req_word_type s1_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         s1_word_ff <= req_word;
      end
   end

   // ---- stage 1 logic: products and numerators ------------------------
   logic [7:0]       s1_alpha;
   logic [7:0]       s1_inv_alpha;
   logic [7:0]       s1_src  [3];
   logic [7:0]       s1_dst  [3];
   logic [15:0]      s1_p_sa [3];
   logic [15:0]      s1_p_di [3];
   logic [16:0]      s1_blend[3];
   logic [NUM_W-1:0] s1_p_vm [3];
   logic [NUM_W-1:0] num_in  [3];
   logic [15:0]      anum_in;
   logic             we_in;

   always_comb begin
      s1_alpha     = s1_word_ff.src_pixel[31:24];
      s1_inv_alpha = 8'd255 - s1_alpha;
      for (int c = 0; c < 3; c++) begin
         s1_src[c]   = s1_word_ff.src_pixel[8*c +: 8];
         s1_dst[c]   = s1_word_ff.dst_pixel[8*c +: 8];
         s1_p_sa[c]  = {8'd0, s1_src[c]} * {8'd0, s1_alpha};
         s1_p_di[c]  = {8'd0, s1_dst[c]} * {8'd0, s1_inv_alpha};
         s1_blend[c] = {1'b0, s1_p_sa[c]} + {1'b0, s1_p_di[c]} + 17'd127;
         s1_p_vm[c]  = {16'd0, s1_src[c]} * {8'd0, mask_norm_ff[c]};
         num_in[c]   = (fmt_cfg_ff == FMT_16BPP) ? (s1_p_vm[c] + 24'd127)
                                                 : {7'd0, s1_blend[c]};
      end
      anum_in = {8'd0, s1_word_ff.dst_pixel[31:24]} * {8'd0, s1_inv_alpha};
      // No store for a transparent source or an unused format code.
      we_in   = (s1_alpha != 8'd0) && (fmt_cfg_ff == FMT_16BPP ||
                fmt_cfg_ff == FMT_24BPP || fmt_cfg_ff == FMT_32BPP);
   end

   // ---- stage 2: numerator register ----------------------------------
   logic             s2_valid_ff;
   logic [NUM_W-1:0] num_ff  [3];
   logic [15:0]      anum_ff;
   logic [7:0]       alpha_ff;
   logic             we_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= num_in[0];
      num_ff[1] <= num_in[1];
      num_ff[2] <= num_in[2];
      anum_ff   <= anum_in;
      alpha_ff  <= s1_alpha;
      we_ff     <= we_in;
   end

   // ---- stage 2 logic: divide by 255 and assemble ---------------------
   logic [QUO_W-1:0] quo   [3];
   logic [QUO_W-1:0] quo_a;
   logic [31:0]      packed16;
   logic [7:0]       alpha_out;
   rsp_word_type     rsp_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         quo[c] = div255(num_ff[c]);
      end
      quo_a     = div255({8'd0, anum_ff});
      alpha_out = alpha_ff + quo_a[7:0];
      packed16  = (32'(quo[2]) << mask_shift_ff[2]) |
                  (32'(quo[1]) << mask_shift_ff[1]) |
                  (32'(quo[0]) << mask_shift_ff[0]);
      rsp_in.write_enable = we_ff;
      rsp_in.new_pixel    = '0;
      if (we_ff) begin
         case (fmt_cfg_ff)
            FMT_16BPP: rsp_in.new_pixel = {16'd0, packed16[15:0]};
            FMT_24BPP: rsp_in.new_pixel = {8'd0, quo[2][7:0], quo[1][7:0],
                                           quo[0][7:0]};
            FMT_32BPP: rsp_in.new_pixel = {alpha_out, quo[2][7:0],
                                           quo[1][7:0], quo[0][7:0]};
            default:   rsp_in.new_pixel = '0;
         endcase
      end
   end

   // ---- stage 3: result register --------------------------------------
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
